@@ design/matrix_multiply_accumulate_defines.svh @@
// ---------------------------------------------------------------------------
// matrix_multiply_accumulate_defines.svh
// assertion macros shared by the matrix multiply-accumulate modules
// ---------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ACCUMULATE_DEFINES_SVH
`define MATRIX_MULTIPLY_ACCUMULATE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define MMA_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define MMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/mma_pkg.sv @@
// ---------------------------------------------------------------------------
// mma_pkg
// types, codes and sizes shared by the matrix multiply-accumulate block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mma_pkg;

    // store geometry
    localparam int MAX_DIM = 64;
    localparam int IDX_W   = 6;
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int SIZE_W  = 7;
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_DIM);
    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_DIM);

    // data widths
    localparam int CMD_W  = 3;
    localparam int OPND_W = 16;
    localparam int PROD_W = 2 * OPND_W;
    localparam int ACC_W  = 48;
    localparam int SUM_W  = PROD_W + IDX_W + 1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD_A  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD_C  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_C  = 3'd4;

    // result kinds
    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // input item
    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [OPND_W-1:0] operand;
        logic signed [ACC_W-1:0]  acc_init;
    } mma_req_t;

    // result item
    typedef struct packed {
        logic                    kind;
        logic signed [ACC_W-1:0] data_value;
    } mma_rsp_t;

    // classified command held in the queue
    typedef struct packed {
        logic [CMD_W-1:0]         op;
        logic [ADDR_W-1:0]        addr;
        logic signed [OPND_W-1:0] operand;
        logic signed [ACC_W-1:0]  acc;
    } mma_op_t;

    // queue head as seen by the engine
    typedef struct packed {
        logic    valid;
        mma_op_t head;
    } mma_queue_t;

endpackage

@@ design/mma_front.sv @@
// ---------------------------------------------------------------------------
// mma_front
// accepts command items, drops unused codes and queues the rest
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mma_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  mma_pkg::mma_req_t   request,
    output mma_pkg::mma_queue_t queue,
    input  logic                pop
);
    import mma_pkg::*;

    mma_op_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                accept;
    logic                push;
    mma_op_t             new_op;

    // classify the incoming item
    assign busy   = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign accept = start && !busy;
    assign push   = accept && (request.cmd <= CMD_READ_C);

    always_comb
    begin
        new_op.op      = request.cmd;
        new_op.addr    = {request.row, request.col};
        new_op.operand = request.operand;
        new_op.acc     = request.acc_init;
    end

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_op;
        end
    end

    assign queue.valid = (count_reg != '0);
    assign queue.head  = entry_reg[rd_ptr_reg];

endmodule

@@ design/mma_back.sv @@
// ---------------------------------------------------------------------------
// mma_back
// executes queued commands: store loads, element reads and the
// multiply-accumulate walk over the matrices
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "matrix_multiply_accumulate_defines.svh"

module mma_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mma_pkg::mma_queue_t          queue,
    output logic                         pop,
    input  logic [mma_pkg::SIZE_W-1:0]   matrix_size,
    output logic                         strobe,
    output mma_pkg::mma_rsp_t            result
);
    import mma_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    // operand and accumulator stores
    logic signed [OPND_W-1:0] a_mem [MAX_DIM*MAX_DIM];
    logic signed [OPND_W-1:0] b_mem [MAX_DIM*MAX_DIM];
    logic signed [ACC_W-1:0]  c_mem [MAX_DIM*MAX_DIM];

    // control
    logic [1:0]        state_reg, state_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic              issue;
    logic              walk_end;
    logic              drained;
    logic              done_fire;
    logic [SIZE_W-1:0] n_eff;
    logic [IDX_W-1:0]  last_idx;

    // pipeline valid flags
    logic              s1_vld_reg, s2_vld_reg, fin_vld_reg, rd_vld_reg;
    logic              s1_first_reg, s1_last_reg, s2_first_reg, s2_last_reg;
    logic [ADDR_W-1:0] s1_addr_reg, s2_addr_reg, fin_addr_reg;

    // pipeline data
    logic signed [OPND_W-1:0] a_rd_reg, b_rd_reg;
    logic signed [ACC_W-1:0]  c_rd_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  sum_reg, sum_total;
    logic signed [SUM_W-1:0]  fin_sum_reg;
    logic signed [ACC_W-1:0]  fin_c_reg;
    logic signed [ACC_W:0]    acc_wide;
    logic signed [ACC_W-1:0]  acc_sat;
    logic [ADDR_W-1:0]        c_raddr;

    // output
    logic     strobe_reg;
    mma_rsp_t rsp_reg;

    // effective size and walk limits
    assign n_eff    = (matrix_size > SIZE_MAX) ? SIZE_MAX : matrix_size;
    assign last_idx = IDX_W'(n_eff - 1'b1);

    assign pop      = queue.valid && (state_reg == ST_IDLE);
    assign issue    = (state_reg == ST_RUN);
    assign walk_end = (k_reg == last_idx) && (j_reg == last_idx) && (i_reg == last_idx);
    assign drained  = !s1_vld_reg && !s2_vld_reg && !fin_vld_reg && !rd_vld_reg;
    assign done_fire = (state_reg == ST_DRAIN) && drained;

    // sequencer: walks k fastest, then j, then i
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop && (queue.head.op == CMD_COMPUTE))
                begin
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = (n_eff == '0) ? ST_DRAIN : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (k_reg == last_idx)
                begin
                    k_next = '0;
                    if (j_reg == last_idx)
                    begin
                        j_next = '0;
                        i_next = i_reg + 1'b1;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
                if (walk_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drained)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            fin_vld_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            s1_vld_reg  <= issue;
            s2_vld_reg  <= s1_vld_reg;
            fin_vld_reg <= s2_vld_reg && s2_last_reg;
            rd_vld_reg  <= pop && (queue.head.op == CMD_READ_C);
            strobe_reg  <= rd_vld_reg || done_fire;
        end
    end

    // pipeline tags
    always_ff @(posedge clk)
    begin
        s1_first_reg <= (k_reg == '0);
        s1_last_reg  <= (k_reg == last_idx);
        s1_addr_reg  <= {i_reg, j_reg};
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_addr_reg  <= s1_addr_reg;
    end

    // operand reads for the current k step
    always_ff @(posedge clk)
    begin
        a_rd_reg <= a_mem[{i_reg, k_reg}];
        b_rd_reg <= b_mem[{j_reg, k_reg}];
    end

    // accumulator read: command address when idle, walk address otherwise
    assign c_raddr = (state_reg == ST_IDLE) ? queue.head.addr : s1_addr_reg;

    always_ff @(posedge clk)
    begin
        c_rd_reg <= c_mem[c_raddr];
    end

    // product stage
    always_ff @(posedge clk)
    begin
        prod_reg <= a_rd_reg * b_rd_reg;
    end

    // running dot product
    assign sum_total = (s2_first_reg ? '0 : sum_reg) + SUM_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (s2_vld_reg)
        begin
            sum_reg <= sum_total;
        end
        if (s2_vld_reg && s2_last_reg)
        begin
            fin_sum_reg  <= sum_total;
            fin_c_reg    <= c_rd_reg;
            fin_addr_reg <= s2_addr_reg;
        end
    end

    // saturating write-back value
    assign acc_wide = (ACC_W+1)'(fin_c_reg) + (ACC_W+1)'(fin_sum_reg);

    always_comb
    begin
        if (acc_wide[ACC_W] != acc_wide[ACC_W-1])
        begin
            acc_sat = acc_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            acc_sat = acc_wide[ACC_W-1:0];
        end
    end

    // store writes
    always_ff @(posedge clk)
    begin
        if (pop && (queue.head.op == CMD_LOAD_A))
        begin
            a_mem[queue.head.addr] <= queue.head.operand;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && (queue.head.op == CMD_LOAD_B))
        begin
            b_mem[queue.head.addr] <= queue.head.operand;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_vld_reg)
        begin
            c_mem[fin_addr_reg] <= acc_sat;
        end
        else if (pop && (queue.head.op == CMD_LOAD_C))
        begin
            c_mem[queue.head.addr] <= queue.head.acc;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            rsp_reg.kind       <= KIND_READ;
            rsp_reg.data_value <= c_rd_reg;
        end
        else
        begin
            rsp_reg.kind       <= KIND_DONE;
            rsp_reg.data_value <= '0;
        end
    end

    assign strobe = strobe_reg;
    assign result = rsp_reg;

    // write-back never shares the accumulator port with a queued command
    `MMA_ASSERT(a_wb_no_pop, clk, rst_n, fin_vld_reg, !pop, "write-back during pop")
    // completion only after the walk has fully drained
    `MMA_ASSERT(a_done_drained, clk, rst_n, strobe_reg && (rsp_reg.kind == KIND_DONE), !s1_vld_reg && !s2_vld_reg && !fin_vld_reg, "completion before drain")
    // an element read is returned on the following cycle
    `MMA_ASSERT_NEXT(a_read_returns, clk, rst_n, rd_vld_reg, strobe_reg && (rsp_reg.kind == KIND_READ), "read data not returned")

endmodule

@@ design/matrix_multiply_accumulate.sv @@
// ---------------------------------------------------------------------------
// matrix_multiply_accumulate
// square matrix multiply-accumulate engine, C += A * B^T, with a
// command channel, a result strobe and an APB-style size register
// ---------------------------------------------------------------------------
// usage:
//   command items (load A, load B, load C, compute, read C) are taken when
//   start is high and busy is low; busy rises only when the four-entry
//   command queue is full, so loads stream at one item per cycle unless a
//   compute ahead of them occupies the engine
// command handling (engine idle when the item is taken):
//   a load waits in the command queue and is written when the engine pops it
//   a read C is popped, its element registered and then driven on strobe
//   a compute occupies the engine while its single multiply-accumulate pipe
//   forms the n^3 products (one product per cycle) and drains; strobe with
//   kind = done rises once the pipe has drained, also for size zero; items
//   queued behind it wait until the engine is idle again
// reset: the queue and engine go idle, matrix_size returns to 64; the
//   matrix stores are undefined until loaded
// results are shown on strobe for one cycle and cannot be held off
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_multiply_accumulate (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  mma_pkg::mma_req_t request,
    output logic              strobe,
    output mma_pkg::mma_rsp_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import mma_pkg::*;

    logic [SIZE_W-1:0] size_reg, size_next;
    mma_queue_t        queue;
    logic              pop;
    logic              size_wr;

    // size register
    assign pready  = 1'b1;
    assign size_wr = psel && penable && pwrite && pready && !paddr[2];

    always_comb
    begin
        size_next = size_wr ? pwdata[SIZE_W-1:0] : size_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else
        begin
            size_reg <= size_next;
        end
    end

    assign prdata = paddr[2] ? '0 : {{(32-SIZE_W){1'b0}}, size_reg};

    // command intake and queue
    mma_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .queue   (queue),
        .pop     (pop)
    );

    // execution engine
    mma_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue       (queue),
        .pop         (pop),
        .matrix_size (size_reg),
        .strobe      (strobe),
        .result      (result)
    );

endmodule
